>>> rtl/vnorm_pkg.sv
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants for the 3D vector normalization core.
// ----------------------------------------------------------------------------
package vnorm_pkg;

	localparam int unsigned CompW     = 32;
	localparam int unsigned RootSteps = 32;  // one root bit per stage
	localparam int unsigned QuotSteps = 31;  // quotient bits 30..0
	// accepting edge to the edge that loads the result register
	localparam int unsigned Latency   = 3 + RootSteps + 1 + QuotSteps;

	typedef struct packed {
		logic signed [CompW-1:0] x_in;
		logic signed [CompW-1:0] y_in;
		logic signed [CompW-1:0] z_in;
	} vec_in_t;

	typedef struct packed {
		logic signed [CompW-1:0] x_unit;
		logic signed [CompW-1:0] y_unit;
		logic signed [CompW-1:0] z_unit;
		logic        [CompW-1:0] magnitude;
		logic                    zero_length;
	} vec_out_t;

	typedef struct packed {
		logic [2*CompW-1:0] sum;
		logic [CompW+1:0]   rem;
		logic [CompW-1:0]   root;
		logic [CompW-1:0]   ax;
		logic [CompW-1:0]   ay;
		logic [CompW-1:0]   az;
		logic [2:0]         neg;
	} root_stage_t;

	typedef struct packed {
		logic [CompW-1:0]         len;
		logic [2:0][CompW-1:0]    rem;
		logic [2:0][QuotSteps-1:0] quo;
		logic [2:0]               lsb;
		logic [2:0]               neg;
		logic                     zero;
	} quot_stage_t;

endpackage

>>> rtl/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Normalizes a Q16.16 3D vector to a Q2.30 unit vector and returns its length.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive start high with the vector on cmd; the transfer
//   happens at the rising edge where start is high and busy is low. busy is
//   always low, so a vector may be sent in every cycle.
//   Result channel: done is high for exactly one cycle with the result on res.
//   The receiver cannot hold results off; every result is presented once.
// Stages: abs, square, sum, 32 root stages, divider setup, 31 divider stages,
//   output register.
// Throughput: one vector per cycle; every stage takes a new item each cycle.
//   The latency is set by the bit-per-stage square root and the three
//   bit-per-stage restoring dividers.
// Reset: arst_n low clears all valid bits; items in flight are dropped and
//   no result is shown until new vectors are accepted.
// A zero vector returns zero components, zero magnitude and zero_length set.
// ----------------------------------------------------------------------------
module vector3_normalize_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  vnorm_pkg::vec_in_t  cmd,
	output logic                done,
	output vnorm_pkg::vec_out_t res
);

	localparam int unsigned W  = vnorm_pkg::CompW;
	localparam int unsigned RS = vnorm_pkg::RootSteps;
	localparam int unsigned QS = vnorm_pkg::QuotSteps;

	// Pipeline never stalls.
	assign busy = 1'b0;

	// Stage 1: magnitudes and signs.
	logic            vld_s1;
	logic [W-1:0]    ax_s1, ay_s1, az_s1;
	logic [2:0]      neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		ax_s1  <= cmd.x_in[W-1] ? W'(-cmd.x_in) : W'(cmd.x_in);
		ay_s1  <= cmd.y_in[W-1] ? W'(-cmd.y_in) : W'(cmd.y_in);
		az_s1  <= cmd.z_in[W-1] ? W'(-cmd.z_in) : W'(cmd.z_in);
		neg_s1 <= {cmd.z_in[W-1], cmd.y_in[W-1], cmd.x_in[W-1]};
	end

	// Stage 2: squares.
	logic            vld_s2;
	logic [2*W-1:0]  xx_s2, yy_s2, zz_s2;
	logic [W-1:0]    ax_s2, ay_s2, az_s2;
	logic [2:0]      neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		xx_s2  <= (2*W)'(ax_s1) * (2*W)'(ax_s1);
		yy_s2  <= (2*W)'(ay_s1) * (2*W)'(ay_s1);
		zz_s2  <= (2*W)'(az_s1) * (2*W)'(az_s1);
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;
		az_s2  <= az_s1;
		neg_s2 <= neg_s1;
	end

	// Stage 3: sum of squares, seeds the root pipeline.
	logic                    rt_vld [0:RS];
	vnorm_pkg::root_stage_t  rt     [0:RS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_vld[0] <= 1'b0;
		else         rt_vld[0] <= vld_s2;
	end

	always_ff @(posedge clk) begin
		rt[0].sum  <= xx_s2 + yy_s2 + zz_s2;
		rt[0].rem  <= '0;
		rt[0].root <= '0;
		rt[0].ax   <= ax_s2;
		rt[0].ay   <= ay_s2;
		rt[0].az   <= az_s2;
		rt[0].neg  <= neg_s2;
	end

	// Root stages: bring in two radicand bits, decide one root bit.
	for (genvar k = 0; k < RS; k++) begin : g_root
		localparam int unsigned Lo = 2 * (RS - 1 - k);
		logic [W+3:0]            shifted, trial;
		logic                    take;
		vnorm_pkg::root_stage_t  nxt;

		always_comb begin
			shifted  = {rt[k].rem, rt[k].sum[Lo+1:Lo]};
			trial    = {2'b00, rt[k].root, 2'b01};
			take     = (shifted >= trial);
			nxt      = rt[k];
			nxt.rem  = take ? (W+2)'(shifted - trial) : (W+2)'(shifted);
			nxt.root = {rt[k].root[W-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_vld[k+1] <= 1'b0;
			else         rt_vld[k+1] <= rt_vld[k];
		end

		always_ff @(posedge clk) begin
			rt[k+1] <= nxt;
		end
	end

	// Divider setup: start each remainder at the component halved.
	logic                    qt_vld [0:QS];
	vnorm_pkg::quot_stage_t  qt     [0:QS];
	logic [2:0][W-1:0]       mag_cmp;

	assign mag_cmp = {rt[RS].az, rt[RS].ay, rt[RS].ax};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) qt_vld[0] <= 1'b0;
		else         qt_vld[0] <= rt_vld[RS];
	end

	always_ff @(posedge clk) begin
		qt[0].len  <= rt[RS].root;
		qt[0].quo  <= '0;
		qt[0].neg  <= rt[RS].neg;
		qt[0].zero <= (rt[RS].root == '0);
		for (int c = 0; c < 3; c++) begin
			qt[0].rem[c] <= {1'b0, mag_cmp[c][W-1:1]};
			qt[0].lsb[c] <= mag_cmp[c][0];
		end
	end

	// Divider stages: one quotient bit per component per stage.
	for (genvar j = 0; j < QS; j++) begin : g_quot
		logic [2:0][W:0]         shifted;
		logic [2:0]              take;
		vnorm_pkg::quot_stage_t  nxt;

		always_comb begin
			nxt = qt[j];
			for (int c = 0; c < 3; c++) begin
				shifted[c] = {qt[j].rem[c], (j == 0) ? qt[j].lsb[c] : 1'b0};
				take[c]    = (shifted[c] >= {1'b0, qt[j].len});
				nxt.rem[c] = take[c] ? W'(shifted[c] - {1'b0, qt[j].len})
				                     : W'(shifted[c]);
				nxt.quo[c] = {qt[j].quo[c][QS-2:0], take[c]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qt_vld[j+1] <= 1'b0;
			else         qt_vld[j+1] <= qt_vld[j];
		end

		always_ff @(posedge clk) begin
			qt[j+1] <= nxt;
		end
	end

	// Output register: apply signs, force zero vector results.
	logic [2:0][W-1:0] unit_val;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (qt[QS].zero)
				unit_val[c] = '0;
			else if (qt[QS].neg[c])
				unit_val[c] = W'(-{1'b0, qt[QS].quo[c]});
			else
				unit_val[c] = W'({1'b0, qt[QS].quo[c]});
		end
	end

	logic done_q;
	vnorm_pkg::vec_out_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= qt_vld[QS];
	end

	always_ff @(posedge clk) begin
		res_q.x_unit      <= unit_val[0];
		res_q.y_unit      <= unit_val[1];
		res_q.z_unit      <= unit_val[2];
		res_q.magnitude   <= qt[QS].len;
		res_q.zero_length <= qt[QS].zero;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> rtl/vnorm_checker.sv
// ----------------------------------------------------------------------------
// vnorm_checker
// Port-level checks for the normalization core, bound to the top level.
// ----------------------------------------------------------------------------
module vnorm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input vnorm_pkg::vec_out_t res
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");

	// done is sampled at the edge after the one that loads the result register
	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, vnorm_pkg::Latency + 1))
		else $error("result without matching transfer");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.zero_length |-> res.magnitude == '0 && res.x_unit == '0
			&& res.y_unit == '0 && res.z_unit == '0)
		else $error("zero vector result not cleared");

	a_nonzero_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.zero_length |-> res.magnitude != '0)
		else $error("zero magnitude without flag");

endmodule

bind vector3_normalize_core vnorm_checker u_vnorm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

>>> test/tb_vector3_normalize_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalize_core
// Drives Q16.16 vectors into the normalization core with random gaps and
// checks every result against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_vector3_normalize_core;

	localparam int unsigned CycleLimit = 400000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	vnorm_pkg::vec_in_t  cmd = '0;
	logic                done;
	vnorm_pkg::vec_out_t res;

	vnorm_pkg::vec_out_t pending_units[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	vector3_normalize_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	always #6 clk = ~clk;

	// Hard stop in case results never show up.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Floor square root of a 64-bit sum, digit by digit.
	function automatic logic [63:0] floor_root(input logic [63:0] s);
		logic [63:0] r;
		logic [63:0] b;
		r = 64'd0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Divide one component by the length, truncating toward zero.
	function automatic logic [31:0] unit_of(input logic [31:0] c, input logic [63:0] len);
		logic [63:0] mag;
		logic [63:0] q;
		mag = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
		q = (mag << 30) / len;
		if (c[31]) q = 64'h1_0000_0000 - q;
		return q[31:0];
	endfunction

	function automatic vnorm_pkg::vec_out_t normalize(input vnorm_pkg::vec_in_t v);
		vnorm_pkg::vec_out_t o;
		logic [63:0]         ax, ay, az, len;
		ax = v.x_in[31] ? (64'h1_0000_0000 - {32'd0, v.x_in}) : {32'd0, v.x_in};
		ay = v.y_in[31] ? (64'h1_0000_0000 - {32'd0, v.y_in}) : {32'd0, v.y_in};
		az = v.z_in[31] ? (64'h1_0000_0000 - {32'd0, v.z_in}) : {32'd0, v.z_in};
		len = floor_root(ax * ax + ay * ay + az * az);
		o = '0;
		if (len == 0) begin
			o.zero_length = 1'b1;
		end else begin
			o.x_unit    = unit_of(v.x_in, len);
			o.y_unit    = unit_of(v.y_in, len);
			o.z_unit    = unit_of(v.z_in, len);
			o.magnitude = len[31:0];
		end
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	// Check each strobed result against the oldest prediction.
	always @(posedge clk) begin
		vnorm_pkg::vec_out_t want;
		if (arst_n && done) begin
			if (pending_units.size() == 0) begin
				report("unexpected result", 32'd0, 32'd0);
			end else begin
				want = pending_units.pop_front();
				if (res.x_unit !== want.x_unit) report("x_unit", res.x_unit, want.x_unit);
				if (res.y_unit !== want.y_unit) report("y_unit", res.y_unit, want.y_unit);
				if (res.z_unit !== want.z_unit) report("z_unit", res.z_unit, want.z_unit);
				if (res.magnitude !== want.magnitude)
					report("magnitude", res.magnitude, want.magnitude);
				if (res.zero_length !== want.zero_length)
					report("zero_length", 32'(res.zero_length), 32'(want.zero_length));
			end
		end
	end

	// Present one vector and hold it until the transfer; random gap first.
	task automatic send_vector(input vnorm_pkg::vec_in_t v, input bit gaps);
		int unsigned wait_cycles;
		wait_cycles = gaps ? $urandom_range(0, 13) : 0;
		if (wait_cycles != 0) begin
			start <= 1'b0;
			repeat (wait_cycles) @(negedge clk);
		end
		start <= 1'b1;
		cmd   <= v;
		do @(posedge clk); while (busy);
		pending_units.push_back(normalize(v));
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) - 1;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return $urandom_range(0, 65535) << $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0]        corner[7];
		vnorm_pkg::vec_in_t v;
		corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h0001_0000, 32'hffff_0000};
		send_vector('0, 1'b0);
		foreach (corner[i]) begin
			v.x_in = corner[i];
			v.y_in = corner[(i + 3) % 7];
			v.z_in = corner[(i + 5) % 7];
			send_vector(v, 1'b0);
			send_vector('{x_in: corner[i], y_in: 32'd0, z_in: 32'd0}, 1'b1);
		end
		send_vector('{x_in: 32'h8000_0000, y_in: 32'h8000_0000, z_in: 32'h8000_0000}, 1'b0);
		send_vector('{x_in: 32'h7fff_ffff, y_in: 32'h7fff_ffff, z_in: 32'h7fff_ffff}, 1'b0);
		send_vector('{x_in: 32'd0, y_in: 32'd0, z_in: 32'h8000_0000}, 1'b0);
	endtask

	// Random vectors: each stretch of 50 runs at full rate or with random gaps.
	task automatic test_random();
		vnorm_pkg::vec_in_t v;
		bit                 gaps;
		for (int n = 0; n < 1700; n++) begin
			if (n % 50 == 0) gaps = $urandom_range(0, 1);
			v.x_in = pick_comp();
			v.y_in = pick_comp();
			v.z_in = pick_comp();
			send_vector(v, gaps);
		end
		start <= 1'b0;
	endtask

	task automatic drain();
		while (pending_units.size() != 0) @(negedge clk);
		repeat (vnorm_pkg::Latency + 10) @(negedge clk);
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		drain();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
